/* hdl/process_sample_table_with_rates_macros.svh */
// ----------------------------------------------------------------------------
// Process sample table assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SAMPLE_TABLE_WITH_RATES_MACROS_SVH
`define PROCESS_SAMPLE_TABLE_WITH_RATES_MACROS_SVH

// assert on a given clock and active-low reset
`define PSR_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assert on the block clock and reset
`define PSR_ASSERT(label, prop, msg) \
    `PSR_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

/* hdl/psr_pkg.sv */
// ----------------------------------------------------------------------------
// Process sample table package
// Types, constants and helpers shared by the slot table block.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int SLOT_COUNT  = 32;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int DATA_W  = 64;
    localparam int PID_W   = 32;
    localparam int CPU_W   = 14;
    localparam int CORE_W  = 11;
    localparam int LIMIT_W = 6;
    localparam int FREQ_W  = 63;
    localparam int SCALE_W = 21;
    localparam int DEN_W   = 84;
    localparam int PROD_W  = 128;
    localparam int CFG_A_W = 2;

    localparam logic [CFG_A_W-1:0] REG_TICK_FREQ    = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_CPU_CORES    = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_RECORD_LIMIT = 2'd2;

    localparam logic [FREQ_W-1:0]  TICK_FREQ_RST    = 63'd10000000;
    localparam logic [CORE_W-1:0]  CPU_CORES_RST    = 11'd1;
    localparam logic [LIMIT_W-1:0] RECORD_LIMIT_RST = 6'd32;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_DERIVE = 2'd2;

    localparam logic [CPU_W-1:0]   CPU_MAX    = 14'd10000;
    localparam logic [SCALE_W-1:0] CORE_SCALE = 21'd1000;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [PID_W-1:0]  pid;
        logic [DATA_W-1:0] proc_start;
        logic [DATA_W-1:0] capture_ticks;
        logic [DATA_W-1:0] kernel_time;
        logic [DATA_W-1:0] user_time;
        logic [DATA_W-1:0] bytes_read;
        logic [DATA_W-1:0] bytes_written;
        logic [DATA_W-1:0] working_set;
        logic [DATA_W-1:0] private_size;
    } in_t;

    typedef struct packed {
        logic              status;
        logic              record_valid;
        logic [PID_W-1:0]  out_pid;
        logic [DATA_W-1:0] out_working_set;
        logic [DATA_W-1:0] out_private_size;
        logic [CPU_W-1:0]  cpu_hundredths;
        logic [DATA_W-1:0] read_rate;
        logic [DATA_W-1:0] write_rate;
        logic              last;
    } out_t;

    typedef struct packed {
        logic              has_prev;
        logic [PID_W-1:0]  pid;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] cur_capture;
        logic [DATA_W-1:0] cur_kernel;
        logic [DATA_W-1:0] cur_user;
        logic [DATA_W-1:0] cur_read;
        logic [DATA_W-1:0] cur_write;
        logic [DATA_W-1:0] cur_working;
        logic [DATA_W-1:0] cur_private;
        logic [DATA_W-1:0] prev_capture;
        logic [DATA_W-1:0] prev_kernel;
        logic [DATA_W-1:0] prev_user;
        logic [DATA_W-1:0] prev_read;
        logic [DATA_W-1:0] prev_write;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESP,
        ST_FIND,
        ST_LATCH,
        ST_MDEN,
        ST_WDEN,
        ST_MUL,
        ST_WMUL,
        ST_DIV,
        ST_WDIV,
        ST_EMIT,
        ST_EMPTY
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OUT_EMPTY,
        OUT_COMMIT,
        OUT_RECORD
    } out_kind_t;

    typedef enum logic [1:0] {
        MUL_DEN,
        MUL_CPU,
        MUL_RD,
        MUL_WR
    } mul_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      clear_seen;
        logic      scan_run;
        logic      commit_write;
        logic      pick_slot;
        logic      lat_rec;
        logic      mul_start;
        mul_sel_t  mul_sel;
        logic      div_start;
        logic      out_load;
        out_kind_t out_kind;
        logic      d_advance;
        logic      d_finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic calc_ok;
        logic next_found;
        logic at_limit;
        logic n_zero;
        logic rec_last;
        logic mul_done;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [SLOT_W:0] find_first(input logic [SLOT_COUNT-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return {|v, idx};
    endfunction

endpackage

/* hdl/psr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* hdl/psr_mul.sv */
// ----------------------------------------------------------------------------
// Sequential 64x64 multiplier
// Four 32x32 partial products accumulated into a 128-bit result.
// ----------------------------------------------------------------------------
module psr_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [psr_pkg::DATA_W-1:0]  a,
    input  logic [psr_pkg::DATA_W-1:0]  b,
    output logic [psr_pkg::PROD_W-1:0]  p,
    output logic                        done
);

    localparam int HALF = psr_pkg::DATA_W / 2;

    logic [psr_pkg::DATA_W-1:0] a_reg, b_reg, pp_reg;
    logic [psr_pkg::PROD_W-1:0] acc_reg;
    logic [1:0]                 sh_reg;
    logic [2:0]                 cnt_reg;
    logic                       busy_reg, done_reg;
    logic [HALF-1:0]            op_a, op_b;
    logic [1:0]                 sh_next;

    always_comb begin
        op_a    = a_reg[HALF-1:0];
        op_b    = b_reg[HALF-1:0];
        sh_next = 2'd0;
        case (cnt_reg)
            3'd1: begin
                op_b    = b_reg[psr_pkg::DATA_W-1:HALF];
                sh_next = 2'd1;
            end
            3'd2: begin
                op_a    = a_reg[psr_pkg::DATA_W-1:HALF];
                sh_next = 2'd1;
            end
            3'd3: begin
                op_a    = a_reg[psr_pkg::DATA_W-1:HALF];
                op_b    = b_reg[psr_pkg::DATA_W-1:HALF];
                sh_next = 2'd2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_reg <= op_a * op_b;
                sh_reg <= sh_next;
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + (psr_pkg::PROD_W'(pp_reg) << (HALF * sh_reg));
            end
        end
    end

    assign p    = acc_reg;
    assign done = done_reg;

endmodule

/* hdl/psr_div.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Bit-serial quotient of a 128-bit dividend, 64 or 14 quotient bits,
// with an overflow flag when the quotient does not fit.
// ----------------------------------------------------------------------------
module psr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        narrow,
    input  logic [psr_pkg::PROD_W-1:0]  num,
    input  logic [psr_pkg::DEN_W-1:0]   den,
    output logic [psr_pkg::DATA_W-1:0]  q,
    output logic                        sat,
    output logic                        done
);

    localparam int NQ   = psr_pkg::CPU_W;
    localparam int WQ   = psr_pkg::DATA_W;
    localparam int TOPW = psr_pkg::PROD_W - NQ;

    logic [psr_pkg::DEN_W-1:0]  den_reg, r_reg;
    logic [psr_pkg::DATA_W-1:0] bits_reg, q_reg;
    logic [6:0]                 cnt_reg;
    logic                       busy_reg, done_reg, sat_reg;
    logic [TOPW-1:0]            rtop;
    logic                       sat_now;
    logic [psr_pkg::DEN_W:0]    rs, rsub;

    always_comb begin
        rtop    = narrow ? num[psr_pkg::PROD_W-1:NQ]
                         : TOPW'(num[psr_pkg::PROD_W-1:WQ]);
        sat_now = rtop >= TOPW'(den);
        rs      = {r_reg, bits_reg[WQ-1]};
        rsub    = rs - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !sat_now;
                done_reg <= sat_now;
                cnt_reg  <= narrow ? 7'(NQ) : 7'(WQ);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg  <= den;
            r_reg    <= psr_pkg::DEN_W'(rtop);
            bits_reg <= narrow ? {num[NQ-1:0], (WQ - NQ)'(0)} : num[WQ-1:0];
            q_reg    <= '0;
            sat_reg  <= sat_now;
        end else if (busy_reg) begin
            bits_reg <= bits_reg << 1;
            if (!rsub[psr_pkg::DEN_W]) begin
                r_reg <= rsub[psr_pkg::DEN_W-1:0];
                q_reg <= {q_reg[WQ-2:0], 1'b1};
            end else begin
                r_reg <= rs[psr_pkg::DEN_W-1:0];
                q_reg <= {q_reg[WQ-2:0], 1'b0};
            end
        end
    end

    assign q    = q_reg;
    assign sat  = sat_reg;
    assign done = done_reg;

endmodule

/* hdl/psr_dp.sv */
// ----------------------------------------------------------------------------
// Process sample table datapath
// Slot flags, slot record memory, key scan, metric arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module psr_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psr_pkg::dp_cmd_t              cmd,
    output psr_pkg::dp_stat_t             stat,
    input  psr_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output psr_pkg::out_t                 m_data,
    input  logic                          cfg_we,
    input  logic [psr_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [psr_pkg::FREQ_W-1:0]    cfg_wdata
);

    localparam int N  = psr_pkg::SLOT_COUNT;
    localparam int SW = psr_pkg::SLOT_W;
    localparam int CW = psr_pkg::CNT_W;
    localparam int DW = psr_pkg::DATA_W;

    psr_pkg::in_t                  in_reg;
    logic [psr_pkg::FREQ_W-1:0]    tick_freq_reg;
    logic [psr_pkg::CORE_W-1:0]    cpu_cores_reg;
    logic [psr_pkg::LIMIT_W-1:0]   record_limit_reg;
    logic [N-1:0]                  used_reg, seen_reg;
    logic [SW-1:0]                 scan_cnt_reg, cmp_idx_reg, hit_idx_reg;
    logic [SW-1:0]                 cur_idx_reg, j_reg;
    logic                          cmp_vld_reg, hit_reg;
    logic [CW-1:0]                 n_reg;
    psr_pkg::slot_rec_t            rec_reg;
    logic [psr_pkg::DEN_W-1:0]     den_reg;
    logic [psr_pkg::CPU_W-1:0]     cpu_reg;
    logic [DW-1:0]                 rr_reg, wr_reg;
    psr_pkg::mul_sel_t             mul_sel_reg;
    logic                          m_valid_reg;
    psr_pkg::out_t                 m_data_reg;

    psr_pkg::slot_rec_t            rdata, wdata;
    logic [SW-1:0]                 raddr, waddr;
    logic                          we;
    logic                          key_match;
    logic [SW:0]                   ff_free, ff_stale, ff_next;
    logic                          room;
    logic [N-1:0]                  cand, more_vec;
    logic [CW-1:0]                 lim_eff;
    logic [CW:0]                   n_plus;
    logic [DW-1:0]                 ticks, cpu_delta, dr, dw;
    logic [psr_pkg::SCALE_W-1:0]   cores_scaled;
    logic [DW-1:0]                 mul_a, mul_b;
    logic [psr_pkg::PROD_W-1:0]    mul_p;
    logic                          mul_done, div_done, div_sat;
    logic [DW-1:0]                 div_q;
    logic [psr_pkg::DEN_W-1:0]     div_den;
    logic                          div_narrow;
    logic [psr_pkg::CORE_W-1:0]    cores_eff;
    psr_pkg::out_t                 out_next;

    psr_ram #(
        .WIDTH (psr_pkg::REC_W),
        .DEPTH (N)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    psr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .p       (mul_p),
        .done    (mul_done)
    );

    psr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .narrow  (div_narrow),
        .num     (mul_p),
        .den     (div_den),
        .q       (div_q),
        .sat     (div_sat),
        .done    (div_done)
    );

    always_comb begin
        key_match = used_reg[cmp_idx_reg] && (rdata.pid == in_reg.pid)
                    && (rdata.start == in_reg.proc_start);
        ff_free   = psr_pkg::find_first(~used_reg);
        ff_stale  = psr_pkg::find_first(used_reg & ~seen_reg);
        room      = hit_reg || ff_free[SW] || ff_stale[SW];
        waddr     = hit_reg ? hit_idx_reg : (ff_free[SW] ? ff_free[SW-1:0] : ff_stale[SW-1:0]);
        we        = cmd.commit_write && room;

        wdata = rec_reg;
        if (hit_reg) begin
            wdata.has_prev     = 1'b1;
            wdata.prev_capture = rec_reg.cur_capture;
            wdata.prev_kernel  = rec_reg.cur_kernel;
            wdata.prev_user    = rec_reg.cur_user;
            wdata.prev_read    = rec_reg.cur_read;
            wdata.prev_write   = rec_reg.cur_write;
        end else begin
            wdata.has_prev     = 1'b0;
            wdata.pid          = in_reg.pid;
            wdata.start        = in_reg.proc_start;
            wdata.prev_capture = '0;
            wdata.prev_kernel  = '0;
            wdata.prev_user    = '0;
            wdata.prev_read    = '0;
            wdata.prev_write   = '0;
        end
        wdata.cur_capture = in_reg.capture_ticks;
        wdata.cur_kernel  = in_reg.kernel_time;
        wdata.cur_user    = in_reg.user_time;
        wdata.cur_read    = in_reg.bytes_read;
        wdata.cur_write   = in_reg.bytes_written;
        wdata.cur_working = in_reg.working_set;
        wdata.cur_private = in_reg.private_size;

        cand     = used_reg & seen_reg & ~((N'(1) << j_reg) - N'(1));
        ff_next  = psr_pkg::find_first(cand);
        raddr    = cmd.scan_run ? scan_cnt_reg : ff_next[SW-1:0];
        more_vec = used_reg & seen_reg & ~((N'(2) << cur_idx_reg) - N'(1));
        lim_eff  = (CW'(record_limit_reg) > CW'(psr_pkg::MAX_RESULTS))
                   ? CW'(psr_pkg::MAX_RESULTS) : CW'(record_limit_reg);
        n_plus   = {1'b0, n_reg} + (CW + 1)'(1);

        ticks        = rec_reg.cur_capture - rec_reg.prev_capture;
        cpu_delta    = (rec_reg.cur_kernel - rec_reg.prev_kernel)
                       + (rec_reg.cur_user - rec_reg.prev_user);
        dr           = (rec_reg.cur_read >= rec_reg.prev_read)
                       ? rec_reg.cur_read - rec_reg.prev_read : '0;
        dw           = (rec_reg.cur_write >= rec_reg.prev_write)
                       ? rec_reg.cur_write - rec_reg.prev_write : '0;
        cores_eff    = (cpu_cores_reg == '0) ? psr_pkg::CORE_W'(1) : cpu_cores_reg;
        cores_scaled = psr_pkg::SCALE_W'(cores_eff * psr_pkg::CORE_SCALE);

        unique case (cmd.mul_sel)
            psr_pkg::MUL_DEN: begin
                mul_a = ticks;
                mul_b = DW'(cores_scaled);
            end
            psr_pkg::MUL_CPU: begin
                mul_a = cpu_delta;
                mul_b = DW'(tick_freq_reg);
            end
            psr_pkg::MUL_RD: begin
                mul_a = dr;
                mul_b = DW'(tick_freq_reg);
            end
            default: begin
                mul_a = dw;
                mul_b = DW'(tick_freq_reg);
            end
        endcase
        div_narrow = (mul_sel_reg == psr_pkg::MUL_CPU);
        div_den    = div_narrow ? den_reg : psr_pkg::DEN_W'(ticks);

        stat.scan_hit   = cmd.scan_run && cmp_vld_reg && key_match;
        stat.scan_end   = cmd.scan_run && cmp_vld_reg && (cmp_idx_reg == SW'(N - 1));
        stat.calc_ok    = rec_reg.has_prev && (tick_freq_reg != '0) && (ticks != '0)
                          && !ticks[DW-1];
        stat.next_found = ff_next[SW];
        stat.at_limit   = n_reg >= lim_eff;
        stat.n_zero     = (n_reg == '0);
        stat.rec_last   = !(|more_vec) || (n_plus >= {1'b0, lim_eff});
        stat.mul_done   = mul_done;
        stat.div_done   = div_done;
        stat.out_free   = !m_valid_reg || m_ready;

        out_next      = '0;
        out_next.last = 1'b1;
        unique case (cmd.out_kind)
            psr_pkg::OUT_COMMIT: begin
                out_next.status = !room;
            end
            psr_pkg::OUT_RECORD: begin
                out_next.record_valid     = 1'b1;
                out_next.out_pid          = rec_reg.pid;
                out_next.out_working_set  = rec_reg.cur_working;
                out_next.out_private_size = rec_reg.cur_private;
                out_next.cpu_hundredths   = cpu_reg;
                out_next.read_rate        = rr_reg;
                out_next.write_rate       = wr_reg;
                out_next.last             = stat.rec_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_freq_reg    <= psr_pkg::TICK_FREQ_RST;
            cpu_cores_reg    <= psr_pkg::CPU_CORES_RST;
            record_limit_reg <= psr_pkg::RECORD_LIMIT_RST;
            used_reg         <= '0;
            seen_reg         <= '0;
            scan_cnt_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            n_reg            <= '0;
            j_reg            <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    psr_pkg::REG_TICK_FREQ:    tick_freq_reg    <= cfg_wdata;
                    psr_pkg::REG_CPU_CORES:    cpu_cores_reg    <= cfg_wdata[psr_pkg::CORE_W-1:0];
                    psr_pkg::REG_RECORD_LIMIT: record_limit_reg <= cfg_wdata[psr_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.load_in) begin
                scan_cnt_reg <= '0;
                cmp_vld_reg  <= 1'b0;
                hit_reg      <= 1'b0;
                n_reg        <= '0;
                j_reg        <= '0;
            end
            if (cmd.clear_seen) begin
                seen_reg <= '0;
            end
            if (cmd.scan_run) begin
                scan_cnt_reg <= scan_cnt_reg + SW'(1);
                cmp_vld_reg  <= 1'b1;
                if (stat.scan_hit) begin
                    hit_reg <= 1'b1;
                end
            end
            if (we) begin
                used_reg[waddr] <= 1'b1;
                seen_reg[waddr] <= 1'b1;
            end
            if (cmd.d_advance) begin
                n_reg <= n_plus[CW-1:0];
                j_reg <= cur_idx_reg + SW'(1);
            end
            if (cmd.d_finish) begin
                used_reg <= used_reg & seen_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.scan_run) begin
            cmp_idx_reg <= scan_cnt_reg;
            if (stat.scan_hit) begin
                hit_idx_reg <= cmp_idx_reg;
                rec_reg     <= rdata;
            end
        end
        if (cmd.pick_slot) begin
            cur_idx_reg <= ff_next[SW-1:0];
        end
        if (cmd.lat_rec) begin
            rec_reg <= rdata;
            cpu_reg <= '0;
            rr_reg  <= '0;
            wr_reg  <= '0;
        end
        if (cmd.mul_start) begin
            mul_sel_reg <= cmd.mul_sel;
        end
        if (mul_done && (mul_sel_reg == psr_pkg::MUL_DEN)) begin
            den_reg <= mul_p[psr_pkg::DEN_W-1:0];
        end
        if (div_done) begin
            unique case (mul_sel_reg)
                psr_pkg::MUL_CPU: begin
                    cpu_reg <= (div_sat || (div_q[psr_pkg::CPU_W-1:0] > psr_pkg::CPU_MAX))
                               ? psr_pkg::CPU_MAX : div_q[psr_pkg::CPU_W-1:0];
                end
                psr_pkg::MUL_RD: rr_reg <= div_sat ? '1 : div_q;
                psr_pkg::MUL_WR: wr_reg <= div_sat ? '1 : div_q;
                default: begin
                end
            endcase
        end
        if (cmd.out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/psr_ctrl.sv */
// ----------------------------------------------------------------------------
// Process sample table controller
// Sequences begin, commit and derive commands over the datapath.
// ----------------------------------------------------------------------------
module psr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_cmd,
    output logic              s_ready,
    input  psr_pkg::dp_stat_t stat,
    output psr_pkg::dp_cmd_t  cmd
);

    psr_pkg::ctrl_state_t state_reg, state_next;
    psr_pkg::mul_sel_t    phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psr_pkg::ST_IDLE;
            phase_reg <= psr_pkg::MUL_CPU;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            psr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    unique case (s_cmd)
                        psr_pkg::CMD_BEGIN: begin
                            cmd.clear_seen = 1'b1;
                            state_next     = psr_pkg::ST_RESP;
                        end
                        psr_pkg::CMD_COMMIT: state_next = psr_pkg::ST_SCAN;
                        psr_pkg::CMD_DERIVE: state_next = psr_pkg::ST_FIND;
                        default:             state_next = psr_pkg::ST_RESP;
                    endcase
                end
            end
            psr_pkg::ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_hit || stat.scan_end) begin
                    state_next = psr_pkg::ST_COMMIT;
                end
            end
            psr_pkg::ST_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit_write = 1'b1;
                    cmd.out_load     = 1'b1;
                    cmd.out_kind     = psr_pkg::OUT_COMMIT;
                    state_next       = psr_pkg::ST_IDLE;
                end
            end
            psr_pkg::ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = psr_pkg::OUT_EMPTY;
                    state_next   = psr_pkg::ST_IDLE;
                end
            end
            psr_pkg::ST_FIND: begin
                if (stat.next_found && !stat.at_limit) begin
                    cmd.pick_slot = 1'b1;
                    state_next    = psr_pkg::ST_LATCH;
                end else if (stat.n_zero) begin
                    state_next = psr_pkg::ST_EMPTY;
                end else begin
                    cmd.d_finish = 1'b1;
                    state_next   = psr_pkg::ST_IDLE;
                end
            end
            psr_pkg::ST_LATCH: begin
                cmd.lat_rec = 1'b1;
                phase_next  = psr_pkg::MUL_CPU;
                state_next  = psr_pkg::ST_MDEN;
            end
            psr_pkg::ST_MDEN: begin
                if (stat.calc_ok) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = psr_pkg::MUL_DEN;
                    state_next    = psr_pkg::ST_WDEN;
                end else begin
                    state_next = psr_pkg::ST_EMIT;
                end
            end
            psr_pkg::ST_WDEN: begin
                if (stat.mul_done) begin
                    state_next = psr_pkg::ST_MUL;
                end
            end
            psr_pkg::ST_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = phase_reg;
                state_next    = psr_pkg::ST_WMUL;
            end
            psr_pkg::ST_WMUL: begin
                if (stat.mul_done) begin
                    state_next = psr_pkg::ST_DIV;
                end
            end
            psr_pkg::ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = psr_pkg::ST_WDIV;
            end
            psr_pkg::ST_WDIV: begin
                if (stat.div_done) begin
                    unique case (phase_reg)
                        psr_pkg::MUL_CPU: begin
                            phase_next = psr_pkg::MUL_RD;
                            state_next = psr_pkg::ST_MUL;
                        end
                        psr_pkg::MUL_RD: begin
                            phase_next = psr_pkg::MUL_WR;
                            state_next = psr_pkg::ST_MUL;
                        end
                        default: state_next = psr_pkg::ST_EMIT;
                    endcase
                end
            end
            psr_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = psr_pkg::OUT_RECORD;
                    cmd.d_advance = 1'b1;
                    if (stat.rec_last) begin
                        cmd.d_finish = 1'b1;
                        state_next   = psr_pkg::ST_IDLE;
                    end else begin
                        state_next = psr_pkg::ST_FIND;
                    end
                end
            end
            psr_pkg::ST_EMPTY: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = psr_pkg::OUT_EMPTY;
                    cmd.d_finish = 1'b1;
                    state_next   = psr_pkg::ST_IDLE;
                end
            end
            default: state_next = psr_pkg::ST_IDLE;
        endcase
    end

endmodule

/* hdl/process_sample_table_with_rates.sv */
// Begin or unknown command: empty result, registered once the output is free.
// Commit: result follows the key scan over the slot memory. Derive: each metric record
// runs the multiplier (four 32x32 partial products) and the bit-serial divider
// (14 + 64 + 64 quotient bits); suppressed metrics skip both. Derive with no record:
// an empty result. One command at a time; the next transaction is taken once the
// last result is registered. Reset (aresetn low, synchronous) clears slot flags.
// ----------------------------------------------------------------------------
// Process sample table with rates
// Slot table keyed by pid and start time that derives CPU share and I/O rates.
// ----------------------------------------------------------------------------
module process_sample_table_with_rates (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  psr_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output psr_pkg::out_t                 m_data,
    input  logic                          cfg_we,
    input  logic [psr_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [psr_pkg::FREQ_W-1:0]    cfg_wdata
);

    psr_pkg::dp_cmd_t  cmd;
    psr_pkg::dp_stat_t stat;

    psr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    psr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

/* hdl/psr_chk.sv */
// ----------------------------------------------------------------------------
// Process sample table port checker
// Port-level properties of the slot table block, bound to the top level.
// ----------------------------------------------------------------------------
`include "process_sample_table_with_rates_macros.svh"

module psr_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input psr_pkg::in_t                  s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input psr_pkg::out_t                 m_data,
    input logic                          cfg_we,
    input logic [psr_pkg::CFG_A_W-1:0]   cfg_addr,
    input logic [psr_pkg::FREQ_W-1:0]    cfg_wdata
);

    `PSR_ASSERT(a_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "result dropped or changed while stalled")
    `PSR_ASSERT(a_busy, (s_valid && s_ready) |=> !s_ready, "second transaction taken while busy")
    `PSR_ASSERT(a_empty, (m_valid && !m_data.record_valid) |-> (m_data.last && m_data.cpu_hundredths == '0 && m_data.read_rate == '0 && m_data.write_rate == '0 && m_data.out_pid == '0), "empty result carries record data")
    `PSR_ASSERT(a_record, (m_valid && m_data.record_valid) |-> (!m_data.status && m_data.cpu_hundredths <= psr_pkg::CPU_MAX), "record status or CPU share out of range")

endmodule

bind process_sample_table_with_rates psr_chk u_psr_chk (.*);

/* test/process_sample_table_with_rates_tb.sv */
// ----------------------------------------------------------------------------
// Process sample table testbench
// Drives begin, commit and derive commands through the valid/ready input,
// predicts every metric record with an independent slot table model, and
// checks each result transaction field by field under random idling, a long
// receiver hold-off and several register settings.
// ----------------------------------------------------------------------------
module process_sample_table_with_rates_tb;
    import psr_pkg::*;

    localparam int KEYS      = 48;
    localparam int MAX_CYCLE = 5000000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        in_t  item;
        bit   typed;
        out_t want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic cfg_we;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [FREQ_W-1:0]  cfg_wdata;

    // table copy
    bit                tb_used[SLOT_COUNT];
    bit                tb_seen[SLOT_COUNT];
    bit                tb_has_prev[SLOT_COUNT];
    logic [PID_W-1:0]  tb_pid[SLOT_COUNT];
    logic [DATA_W-1:0] tb_start[SLOT_COUNT];
    logic [DATA_W-1:0] tb_cap[SLOT_COUNT], tb_ker[SLOT_COUNT], tb_usr[SLOT_COUNT];
    logic [DATA_W-1:0] tb_rd[SLOT_COUNT], tb_wr[SLOT_COUNT];
    logic [DATA_W-1:0] tb_ws[SLOT_COUNT], tb_ps[SLOT_COUNT];
    logic [DATA_W-1:0] tb_pcap[SLOT_COUNT], tb_pker[SLOT_COUNT], tb_pusr[SLOT_COUNT];
    logic [DATA_W-1:0] tb_prd[SLOT_COUNT], tb_pwr[SLOT_COUNT];
    logic [FREQ_W-1:0]  freq_reg;
    logic [CORE_W-1:0]  cores_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // stimulus key pool and per-key counters
    logic [PID_W-1:0]  key_pid[KEYS];
    logic [DATA_W-1:0] key_start[KEYS];
    logic [DATA_W-1:0] g_cap[KEYS], g_ker[KEYS], g_usr[KEYS], g_rd[KEYS], g_wr[KEYS];

    out_t pending_out[$];
    row_t rows[$];
    int   errors = 0;
    int   sent = 0;
    int   cycles = 0;
    int   src_idle = 14;
    int   dst_idle = 81;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    process_sample_table_with_rates u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [CPU_W-1:0] cpu_share(input logic [DATA_W-1:0] dcpu,
                                                  input logic [DATA_W-1:0] dticks);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        num = 128'(dcpu) * 128'(freq_reg);
        den = 128'(dticks) * 128'(1000) * 128'((cores_reg == 0) ? 1 : cores_reg);
        q   = num / den;
        return (q >= 128'(10000)) ? CPU_W'(10000) : CPU_W'(q);
    endfunction

    function automatic logic [DATA_W-1:0] byte_rate(input logic [DATA_W-1:0] dbytes,
                                                   input logic [DATA_W-1:0] dticks);
        logic [127:0] q;
        q = (128'(dbytes) * 128'(freq_reg)) / 128'(dticks);
        return (q[127:64] != 0) ? {DATA_W{1'b1}} : q[63:0];
    endfunction

    function automatic out_t slot_metrics(input int i);
        out_t r;
        logic [DATA_W-1:0] dt;
        r = '0;
        r.record_valid     = 1'b1;
        r.out_pid          = tb_pid[i];
        r.out_working_set  = tb_ws[i];
        r.out_private_size = tb_ps[i];
        dt = tb_cap[i] - tb_pcap[i];
        if (tb_has_prev[i] && freq_reg != 0 && dt != 0 && !dt[63]) begin
            r.cpu_hundredths = cpu_share((tb_ker[i] - tb_pker[i]) + (tb_usr[i] - tb_pusr[i]), dt);
            r.read_rate  = byte_rate((tb_rd[i] >= tb_prd[i]) ? tb_rd[i] - tb_prd[i] : '0, dt);
            r.write_rate = byte_rate((tb_wr[i] >= tb_pwr[i]) ? tb_wr[i] - tb_pwr[i] : '0, dt);
        end
        return r;
    endfunction

    function automatic logic store_sample(input in_t x);
        int hit;
        int stale;
        hit = -1;
        stale = -1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hit < 0 && tb_used[i] && tb_pid[i] == x.pid && tb_start[i] == x.proc_start) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            tb_pcap[hit] = tb_cap[hit];
            tb_pker[hit] = tb_ker[hit];
            tb_pusr[hit] = tb_usr[hit];
            tb_prd[hit]  = tb_rd[hit];
            tb_pwr[hit]  = tb_wr[hit];
            tb_has_prev[hit] = 1'b1;
        end else begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (hit < 0 && !tb_used[i]) begin
                    hit = i;
                end
                if (hit < 0 && stale < 0 && !tb_seen[i]) begin
                    stale = i;
                end
            end
            if (hit < 0) begin
                hit = stale;
            end
            if (hit < 0) begin
                return 1'b1;
            end
            tb_used[hit]     = 1'b1;
            tb_has_prev[hit] = 1'b0;
            tb_pid[hit]      = x.pid;
            tb_start[hit]    = x.proc_start;
            tb_pcap[hit] = '0;
            tb_pker[hit] = '0;
            tb_pusr[hit] = '0;
            tb_prd[hit]  = '0;
            tb_pwr[hit]  = '0;
        end
        tb_cap[hit] = x.capture_ticks;
        tb_ker[hit] = x.kernel_time;
        tb_usr[hit] = x.user_time;
        tb_rd[hit]  = x.bytes_read;
        tb_wr[hit]  = x.bytes_written;
        tb_ws[hit]  = x.working_set;
        tb_ps[hit]  = x.private_size;
        tb_seen[hit] = 1'b1;
        return 1'b0;
    endfunction

    function automatic void table_predict(input in_t x, ref out_t res[$]);
        out_t r;
        int   lim;
        res = {};
        r = '0;
        if (x.cmd == CMD_DERIVE) begin
            lim = (limit_reg < MAX_RESULTS) ? int'(limit_reg) : MAX_RESULTS;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (tb_used[i] && !tb_seen[i]) begin
                    tb_used[i] = 1'b0;
                end else if (tb_used[i] && res.size() < lim) begin
                    res.push_back(slot_metrics(i));
                end
            end
            if (res.size() == 0) begin
                res.push_back(r);
            end
            res[res.size() - 1].last = 1'b1;
        end else begin
            if (x.cmd == CMD_BEGIN) begin
                foreach (tb_seen[i]) tb_seen[i] = 1'b0;
            end else if (x.cmd == CMD_COMMIT) begin
                r.status = store_sample(x);
            end
            r.last = 1'b1;
            res.push_back(r);
        end
    endfunction

    task automatic send_item(input in_t x, input bit typed, input out_t want);
        out_t res[$];
        while ($urandom_range(99) < src_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = x;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        table_predict(x, res);
        if (typed) begin
            res = {want};
        end
        foreach (res[i]) pending_out.push_back(res[i]);
        sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send(input in_t x);
        send_item(x, 1'b0, '0);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [FREQ_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_TICK_FREQ:    freq_reg  = val;
            REG_CPU_CORES:    cores_reg = val[CORE_W-1:0];
            REG_RECORD_LIMIT: limit_reg = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [FREQ_W-1:0] f, input logic [CORE_W-1:0] c,
                            input logic [LIMIT_W-1:0] l);
        wait_idle();
        write_reg(REG_TICK_FREQ, f);
        write_reg(REG_CPU_CORES, FREQ_W'(c));
        write_reg(REG_RECORD_LIMIT, FREQ_W'(l));
    endtask

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_t make_cmd(input logic [1:0] c);
        in_t x;
        x = '0;
        x.cmd = c;
        x.pid = $urandom;
        x.proc_start = rand64();
        return x;
    endfunction

    function automatic in_t make_sample(input int k);
        in_t x;
        int  p;
        x = '0;
        x.cmd = CMD_COMMIT;
        x.pid = key_pid[k];
        x.proc_start = key_start[k];
        p = $urandom_range(99);
        if (p < 80)       g_cap[k] += $urandom_range(1, 20000000);
        else if (p < 86)  g_cap[k] -= $urandom_range(0, 1000);
        else              g_cap[k] = rand64();
        g_ker[k] = ($urandom_range(19) == 0) ? rand64() : g_ker[k] + $urandom_range(0, 8000000);
        g_usr[k] = ($urandom_range(19) == 0) ? rand64() : g_usr[k] + $urandom_range(0, 8000000);
        p = $urandom_range(99);
        if (p < 80)       g_rd[k] += $urandom;
        else if (p < 90)  g_rd[k] -= $urandom_range(1, 100);
        else              g_rd[k] = rand64();
        p = $urandom_range(99);
        if (p < 80)       g_wr[k] += {$urandom_range(255), $urandom};
        else if (p < 90)  g_wr[k] -= $urandom_range(1, 100);
        else              g_wr[k] = rand64();
        x.capture_ticks = g_cap[k];
        x.kernel_time   = g_ker[k];
        x.user_time     = g_usr[k];
        x.bytes_read    = g_rd[k];
        x.bytes_written = g_wr[k];
        x.working_set   = rand64();
        x.private_size  = rand64();
        return x;
    endfunction

    task automatic run_round(input int goal);
        int n;
        send(make_cmd(CMD_BEGIN));
        n = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(30, 40);
        if (n > goal - sent - 1) n = goal - sent - 1;
        if (n < 1) n = 1;
        repeat (n) send(make_sample($urandom_range(KEYS - 1)));
        if ($urandom_range(9) == 0) begin
            send(make_cmd(($urandom_range(1) == 0) ? CMD_UNKNOWN : CMD_BEGIN));
        end
        send(make_cmd(CMD_DERIVE));
    endtask

    task automatic run_segment(input int count);
        int goal;
        goal = sent + count;
        while (sent < goal) run_round(goal);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %h", $time, m_data);
            end else begin
                want = pending_out.pop_front();
                check_field("status", want.status, m_data.status);
                check_field("record_valid", want.record_valid, m_data.record_valid);
                check_field("out_pid", want.out_pid, m_data.out_pid);
                check_field("out_working_set", want.out_working_set, m_data.out_working_set);
                check_field("out_private_size", want.out_private_size, m_data.out_private_size);
                check_field("cpu_hundredths", want.cpu_hundredths, m_data.cpu_hundredths);
                check_field("read_rate", want.read_rate, m_data.read_rate);
                check_field("write_rate", want.write_rate, m_data.write_rate);
                check_field("last", want.last, m_data.last);
            end
        end
    end

    // hold off for a long stretch on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 400;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= dst_idle);
        end
    end

    task automatic add_row(input in_t x, input bit typed);
        row_t r;
        r.item  = x;
        r.typed = typed;
        r.want  = '0;
        r.want.last = 1'b1;
        rows.push_back(r);
    endtask

    task automatic add_commit(input logic [PID_W-1:0] p, input logic [DATA_W-1:0] st,
                              input logic [DATA_W-1:0] cap, input logic [DATA_W-1:0] cpu,
                              input logic [DATA_W-1:0] io, input bit typed);
        in_t x;
        x = '0;
        x.cmd = CMD_COMMIT;
        x.pid = p;
        x.proc_start = st;
        x.capture_ticks = cap;
        x.kernel_time = cpu;
        x.user_time = cpu;
        x.bytes_read = io;
        x.bytes_written = io;
        x.working_set = ~io;
        x.private_size = io ^ 64'h5555_5555_5555_5555;
        add_row(x, typed);
    endtask

    initial begin
        in_t  x;
        logic [DATA_W-1:0] ones;
        ones = '1;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        m_ready   = 1'b0;
        freq_reg  = TICK_FREQ_RST;
        cores_reg = CPU_CORES_RST;
        limit_reg = RECORD_LIMIT_RST;
        foreach (tb_used[i]) begin
            tb_used[i] = 1'b0;
            tb_seen[i] = 1'b0;
        end
        for (int k = 0; k < KEYS; k++) begin
            key_pid[k]   = $urandom;
            key_start[k] = rand64();
            g_cap[k] = rand64();
            g_ker[k] = rand64();
            g_usr[k] = rand64();
            g_rd[k]  = rand64();
            g_wr[k]  = rand64();
        end
        key_pid[0] = '0;
        key_start[0] = '0;
        key_pid[1] = '1;
        key_start[1] = '1;
        key_pid[3] = key_pid[2];

        x = '0;
        x.cmd = CMD_BEGIN;
        add_row(x, 1'b1);
        x.cmd = CMD_DERIVE;
        add_row(x, 1'b1);
        x = '1;
        x.cmd = CMD_UNKNOWN;
        add_row(x, 1'b1);
        add_commit('0, '0, '0, '0, '0, 1'b1);
        add_commit('1, ones, ones, ones, ones, 1'b1);
        add_commit(32'd2, 64'd5, 64'd1000, 64'd100, 64'd100, 1'b1);
        x = '0;
        x.cmd = CMD_DERIVE;
        add_row(x, 1'b0);
        x.cmd = CMD_BEGIN;
        add_row(x, 1'b1);
        add_commit(32'd2, 64'd5, 64'd10001000, 64'd5000100, 64'd1100, 1'b1);
        add_commit('0, '0, '0, 64'd7, '0, 1'b1);
        add_commit('1, ones, 64'd5, 64'd3, 64'd0, 1'b1);
        x.cmd = CMD_DERIVE;
        add_row(x, 1'b0);
        add_commit(32'd2, 64'd5, 64'd1000, 64'd100, 64'd2000, 1'b1);
        add_row(x, 1'b0);
        x.cmd = CMD_BEGIN;
        add_row(x, 1'b1);
        add_commit(32'd2, 64'd6, 64'd1, 64'd1, 64'd1, 1'b1);
        x.cmd = CMD_DERIVE;
        add_row(x, 1'b0);
        add_row(x, 1'b0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

        set_regs('1, '0, 6'd63);
        run_segment(18);

        src_idle = 81;
        dst_idle = 14;
        set_regs('0, 11'd1024, 6'd0);
        run_segment(18);

        src_idle = 0;
        dst_idle = 0;
        set_regs(63'd10000000, 11'd4, 6'd5);
        hold_req++;
        run_segment(18);

        set_regs({23'd0, $urandom, 8'd0} | 63'd1, 11'd1, 6'd32);
        run_segment(36);

        wait_idle();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
